// ===== rtl/matrix_multiply_core_assert.svh =====
// assertion macros shared by the matrix multiply core
`ifndef MATRIX_MULTIPLY_CORE_ASSERT_SVH
`define MATRIX_MULTIPLY_CORE_ASSERT_SVH

// same-cycle implication, checked at every rising edge outside reset
`define MMC_ASSERT_NOW(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
    else $error("same-cycle check failed");

// next-cycle implication
`define MMC_ASSERT_NEXT(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
    else $error("next-cycle check failed");

`endif

// ===== rtl/mmc_pkg.sv =====
// shared constants and types of the matrix multiply core
package mmc_pkg;

  localparam int MAX_DIM_DEF       = 8;
  localparam int ELEMENT_WIDTH_DEF = 16;

  localparam int DIM_REG_W  = 4;   // width of a dimension register
  localparam int LOAD_CNT_W = 8;   // element counter of one load
  localparam int PRODUCT_W  = 40;  // signed q24.16 result
  localparam int IDX_W      = 3;   // row and column index of a result
  localparam int CFG_ADDR_W = 4;
  localparam int CFG_DATA_W = 32;

  localparam logic [DIM_REG_W-1:0] DIM_RESET = 4'd8;

  // register indexes (byte address / 4)
  localparam logic [1:0] REG_ROWS_A    = 2'd0;
  localparam logic [1:0] REG_INNER_LEN = 2'd1;
  localparam logic [1:0] REG_COLS_B    = 2'd2;

  // dimensions after clamping to 1..max
  typedef struct packed {
    logic [DIM_REG_W-1:0] rows;
    logic [DIM_REG_W-1:0] inner;
    logic [DIM_REG_W-1:0] cols;
  } mmc_dims_t;

  // tag that travels with each multiply through the datapath
  typedef struct packed {
    logic             valid;
    logic             first;  // first term of a dot product
    logic             last;   // last term of a dot product
    logic             fin;    // dot product is the final element of c
    logic [IDX_W-1:0] row;
    logic [IDX_W-1:0] col;
  } mmc_tok_t;

endpackage

// ===== rtl/mmc_regs.sv =====
// apb register file holding the three matrix dimensions
module mmc_regs #(
  parameter int MAX_DIM = mmc_pkg::MAX_DIM_DEF
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            psel,
  input  logic                            penable,
  input  logic                            pwrite,
  input  logic [mmc_pkg::CFG_ADDR_W-1:0]  paddr,
  input  logic [mmc_pkg::CFG_DATA_W-1:0]  pwdata,
  output logic [mmc_pkg::CFG_DATA_W-1:0]  prdata,
  output logic                            pready,
  output mmc_pkg::mmc_dims_t              dims_o,
  output logic                            cfg_wr_o
);

  logic [mmc_pkg::DIM_REG_W-1:0] rows_q, inner_q, cols_q;
  logic [1:0]                    reg_idx;
  logic                          wr_en;

  function automatic logic [mmc_pkg::DIM_REG_W-1:0] clamp_dim(
    input logic [mmc_pkg::DIM_REG_W-1:0] v
  );
    logic [mmc_pkg::DIM_REG_W-1:0] r;
    if (v == '0) begin
      r = mmc_pkg::DIM_REG_W'(1);
    end else if (int'(v) > MAX_DIM) begin
      r = mmc_pkg::DIM_REG_W'(MAX_DIM);
    end else begin
      r = v;
    end
    return r;
  endfunction

  assign reg_idx = paddr[3:2];
  assign wr_en   = psel && penable && pwrite;
  assign pready  = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rows_q  <= mmc_pkg::DIM_RESET;
      inner_q <= mmc_pkg::DIM_RESET;
      cols_q  <= mmc_pkg::DIM_RESET;
    end else if (wr_en) begin
      unique case (reg_idx)
        mmc_pkg::REG_ROWS_A:    rows_q  <= pwdata[mmc_pkg::DIM_REG_W-1:0];
        mmc_pkg::REG_INNER_LEN: inner_q <= pwdata[mmc_pkg::DIM_REG_W-1:0];
        mmc_pkg::REG_COLS_B:    cols_q  <= pwdata[mmc_pkg::DIM_REG_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (reg_idx)
      mmc_pkg::REG_ROWS_A:    prdata = mmc_pkg::CFG_DATA_W'(rows_q);
      mmc_pkg::REG_INNER_LEN: prdata = mmc_pkg::CFG_DATA_W'(inner_q);
      mmc_pkg::REG_COLS_B:    prdata = mmc_pkg::CFG_DATA_W'(cols_q);
      default:                prdata = '0;
    endcase
  end

  // any write to a dimension drops a partial load
  assign cfg_wr_o = wr_en && ((reg_idx == mmc_pkg::REG_ROWS_A) ||
                              (reg_idx == mmc_pkg::REG_INNER_LEN) ||
                              (reg_idx == mmc_pkg::REG_COLS_B));

  assign dims_o.rows  = clamp_dim(rows_q);
  assign dims_o.inner = clamp_dim(inner_q);
  assign dims_o.cols  = clamp_dim(cols_q);

endmodule

// ===== rtl/mmc_mem.sv =====
// single-port-write, single-port-read element memory with registered read
module mmc_mem #(
  parameter int WIDTH  = mmc_pkg::ELEMENT_WIDTH_DEF,
  parameter int DEPTH  = mmc_pkg::MAX_DIM_DEF * mmc_pkg::MAX_DIM_DEF,
  parameter int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic              clk_i,
  input  logic              we_i,
  input  logic [ADDR_W-1:0] waddr_i,
  input  logic [WIDTH-1:0]  wdata_i,
  input  logic              re_i,
  input  logic [ADDR_W-1:0] raddr_i,
  output logic [WIDTH-1:0]  rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // read data holds while re_i is low, so a stalled datapath keeps its operand
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ===== rtl/mmc_mac.sv =====
// shared multiply-accumulate: product register then q24.16 accumulator
module mmc_mac #(
  parameter int ELEMENT_WIDTH = mmc_pkg::ELEMENT_WIDTH_DEF
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                adv_i,
  input  mmc_pkg::mmc_tok_t                   tok_i,
  input  logic signed [ELEMENT_WIDTH-1:0]     a_i,
  input  logic signed [ELEMENT_WIDTH-1:0]     b_i,
  output logic                                done_o,
  output mmc_pkg::mmc_tok_t                   tok_o,
  output logic signed [mmc_pkg::PRODUCT_W-1:0] sum_o
);

  localparam int MUL_W = 2 * ELEMENT_WIDTH;

  mmc_pkg::mmc_tok_t                    tok_q;
  logic signed [MUL_W-1:0]              prod_q;
  logic signed [MUL_W+mmc_pkg::PRODUCT_W-1:0] prod_ext;
  logic signed [mmc_pkg::PRODUCT_W-1:0] prod_fit;
  logic signed [mmc_pkg::PRODUCT_W-1:0] acc_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tok_q <= '0;
    end else if (adv_i) begin
      tok_q <= tok_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv_i && tok_i.valid) begin
      prod_q <= MUL_W'(a_i) * MUL_W'(b_i);
    end
  end

  // sign extend then keep the low 40 bits, which wraps like the result field
  assign prod_ext = (MUL_W + mmc_pkg::PRODUCT_W)'(prod_q);
  assign prod_fit = prod_ext[mmc_pkg::PRODUCT_W-1:0];
  assign sum_o    = tok_q.first ? prod_fit : acc_q + prod_fit;

  always_ff @(posedge clk_i) begin
    if (adv_i && tok_q.valid) begin
      acc_q <= sum_o;
    end
  end

  assign done_o = tok_q.valid && tok_q.last;
  assign tok_o  = tok_q;

endmodule

// ===== rtl/matrix_multiply_core.sv =====
// top level of the dense matrix multiply core
// Computes C = A x B for A of rows_a x inner_len and B of inner_len x cols_b, each
// dimension 1..MAX_DIM (a register value of 0 acts as 1, one above MAX_DIM as
// MAX_DIM). Elements arrive on the slave stream one per transfer, row-major, all
// of A then all of B, as signed q8.8. Loading takes one transfer per cycle; the
// element stores are two synchronous memories written during the load. After the
// last element of B the input stalls while a single shared multiply-accumulate
// walks i, j, k, reading one element of A and one of B per cycle unless a stalled
// output holds it; the sums pass through the read, product and output registers.
// The m*p sums leave row-major on the master stream as signed q24.16 with row and
// column, tlast on the final one; a stalled output freezes the whole compute
// datapath once a finished sum is waiting. The stores have no reset and no
// clearing pass: every entry a run reads is written by that same run. A dimension
// write drops a partial load; write registers only while the core is idle.
`include "matrix_multiply_core_assert.svh"

module matrix_multiply_core #(
  parameter int MAX_DIM       = mmc_pkg::MAX_DIM_DEF,
  parameter int ELEMENT_WIDTH = mmc_pkg::ELEMENT_WIDTH_DEF,
  localparam int IN_W  = ((ELEMENT_WIDTH + 7) / 8) * 8,
  localparam int OUT_W = ((mmc_pkg::PRODUCT_W + 2 * mmc_pkg::IDX_W + 7) / 8) * 8
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  // configuration port
  input  logic                           psel,
  input  logic                           penable,
  input  logic                           pwrite,
  input  logic [mmc_pkg::CFG_ADDR_W-1:0] paddr,
  input  logic [mmc_pkg::CFG_DATA_W-1:0] pwdata,
  output logic [mmc_pkg::CFG_DATA_W-1:0] prdata,
  output logic                           pready,
  // element stream
  input  logic                           s_axis_tvalid,
  output logic                           s_axis_tready,
  input  logic [IN_W-1:0]                s_axis_tdata,  // element_value
  // result stream
  output logic                           m_axis_tvalid,
  input  logic                           m_axis_tready,
  output logic [OUT_W-1:0]               m_axis_tdata,  // product_value, out_row, out_col
  output logic                           m_axis_tlast   // last_of_run
);

  localparam int DEPTH  = MAX_DIM * MAX_DIM;
  localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int DIM_W  = (MAX_DIM > 1) ? $clog2(MAX_DIM) : 1;
  localparam int CNT_W  = mmc_pkg::LOAD_CNT_W;
  localparam int DRW    = mmc_pkg::DIM_REG_W;

  typedef enum logic [1:0] {
    ST_LOAD = 2'b01,
    ST_CALC = 2'b10
  } mmc_state_e;

  // ---------------------------------------------------------------- registers
  mmc_pkg::mmc_dims_t dims;
  logic               cfg_wr;

  mmc_regs #(
    .MAX_DIM (MAX_DIM)
  ) u_regs (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .psel     (psel),
    .penable  (penable),
    .pwrite   (pwrite),
    .paddr    (paddr),
    .pwdata   (pwdata),
    .prdata   (prdata),
    .pready   (pready),
    .dims_o   (dims),
    .cfg_wr_o (cfg_wr)
  );

  // ---------------------------------------------------------------- load side
  mmc_state_e state_q, state_d;
  logic [CNT_W-1:0] load_cnt_q, load_cnt_d;
  logic [CNT_W-1:0] size_a, size_b, total, cnt_inc, b_off;
  logic             in_fire, in_a, load_last, a_we, b_we;
  logic [ELEMENT_WIDTH-1:0] elem;

  assign size_a  = CNT_W'(dims.rows) * CNT_W'(dims.inner);
  assign size_b  = CNT_W'(dims.inner) * CNT_W'(dims.cols);
  assign total   = size_a + size_b;
  assign cnt_inc = load_cnt_q + CNT_W'(1);
  assign b_off   = load_cnt_q - size_a;

  assign s_axis_tready = (state_q == ST_LOAD);
  assign in_fire       = s_axis_tvalid && s_axis_tready;
  assign elem          = s_axis_tdata[ELEMENT_WIDTH-1:0];
  assign in_a          = (load_cnt_q < size_a);
  assign a_we          = in_fire && in_a;
  assign b_we          = in_fire && !in_a;
  assign load_last     = (cnt_inc == total);

  always_comb begin
    load_cnt_d = load_cnt_q;
    if (cfg_wr) begin
      load_cnt_d = '0;
    end else if (in_fire) begin
      load_cnt_d = load_last ? '0 : cnt_inc;
    end
  end

  // ---------------------------------------------------------------- issue sequencer
  logic [DIM_W-1:0]  i_q, j_q, k_q;
  logic [ADDR_W-1:0] a_addr_q, b_addr_q, row_base_q;
  logic [DIM_W-1:0]  m_m1, n_m1, p_m1;
  logic              k_end, j_end, i_end, issue, adv;
  mmc_pkg::mmc_tok_t tok1_q, tok1_d;

  assign m_m1  = DIM_W'(dims.rows - DRW'(1));
  assign n_m1  = DIM_W'(dims.inner - DRW'(1));
  assign p_m1  = DIM_W'(dims.cols - DRW'(1));
  assign k_end = (k_q == n_m1);
  assign j_end = (j_q == p_m1);
  assign i_end = (i_q == m_m1);
  assign issue = (state_q == ST_CALC) && adv;

  always_comb begin
    tok1_d       = '0;
    tok1_d.valid = (state_q == ST_CALC);
    tok1_d.first = (k_q == '0);
    tok1_d.last  = k_end;
    tok1_d.fin   = i_end && j_end;
    tok1_d.row   = mmc_pkg::IDX_W'(i_q);
    tok1_d.col   = mmc_pkg::IDX_W'(j_q);
  end

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_LOAD: if (in_fire && load_last) state_d = ST_CALC;
      ST_CALC: if (adv && k_end && j_end && i_end) state_d = ST_LOAD;
      default: state_d = ST_LOAD;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= ST_LOAD;
      load_cnt_q <= '0;
      i_q        <= '0;
      j_q        <= '0;
      k_q        <= '0;
      a_addr_q   <= '0;
      b_addr_q   <= '0;
      row_base_q <= '0;
      tok1_q     <= '0;
    end else begin
      state_q    <= state_d;
      load_cnt_q <= load_cnt_d;
      if (adv) begin
        tok1_q <= tok1_d;
      end
      if (state_q == ST_LOAD) begin
        // start of a run: everything at the first term of c[0][0]
        i_q        <= '0;
        j_q        <= '0;
        k_q        <= '0;
        a_addr_q   <= '0;
        b_addr_q   <= '0;
        row_base_q <= '0;
      end else if (issue) begin
        if (!k_end) begin
          k_q      <= k_q + DIM_W'(1);
          a_addr_q <= a_addr_q + ADDR_W'(1);
          b_addr_q <= b_addr_q + ADDR_W'(dims.cols);
        end else if (!j_end) begin
          k_q      <= '0;
          j_q      <= j_q + DIM_W'(1);
          a_addr_q <= row_base_q;
          b_addr_q <= ADDR_W'(j_q) + ADDR_W'(1);
        end else begin
          k_q        <= '0;
          j_q        <= '0;
          i_q        <= i_q + DIM_W'(1);
          b_addr_q   <= '0;
          row_base_q <= row_base_q + ADDR_W'(dims.inner);
          a_addr_q   <= row_base_q + ADDR_W'(dims.inner);
        end
      end
    end
  end

  // ---------------------------------------------------------------- element stores
  logic [ELEMENT_WIDTH-1:0] a_rd, b_rd;

  mmc_mem #(
    .WIDTH  (ELEMENT_WIDTH),
    .DEPTH  (DEPTH),
    .ADDR_W (ADDR_W)
  ) u_store_a (
    .clk_i   (clk_i),
    .we_i    (a_we),
    .waddr_i (load_cnt_q[ADDR_W-1:0]),
    .wdata_i (elem),
    .re_i    (issue),
    .raddr_i (a_addr_q),
    .rdata_o (a_rd)
  );

  mmc_mem #(
    .WIDTH  (ELEMENT_WIDTH),
    .DEPTH  (DEPTH),
    .ADDR_W (ADDR_W)
  ) u_store_b (
    .clk_i   (clk_i),
    .we_i    (b_we),
    .waddr_i (b_off[ADDR_W-1:0]),
    .wdata_i (elem),
    .re_i    (issue),
    .raddr_i (b_addr_q),
    .rdata_o (b_rd)
  );

  // ---------------------------------------------------------------- mac and output
  logic                                  mac_done;
  mmc_pkg::mmc_tok_t                     mac_tok;
  logic signed [mmc_pkg::PRODUCT_W-1:0]  mac_sum;
  logic                                  out_valid_q;
  logic                                  out_last_q;
  logic [mmc_pkg::IDX_W-1:0]             out_row_q, out_col_q;
  logic [mmc_pkg::PRODUCT_W-1:0]         out_sum_q;
  logic                                  out_load;

  mmc_mac #(
    .ELEMENT_WIDTH (ELEMENT_WIDTH)
  ) u_mac (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .adv_i  (adv),
    .tok_i  (tok1_q),
    .a_i    (a_rd),
    .b_i    (b_rd),
    .done_o (mac_done),
    .tok_o  (mac_tok),
    .sum_o  (mac_sum)
  );

  // the datapath freezes only when a finished sum meets a full output register
  assign adv      = !(mac_done && out_valid_q && !m_axis_tready);
  assign out_load = mac_done && adv;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (out_load) begin
      out_valid_q <= 1'b1;
    end else if (m_axis_tready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_load) begin
      out_sum_q  <= mac_sum;
      out_row_q  <= mac_tok.row;
      out_col_q  <= mac_tok.col;
      out_last_q <= mac_tok.fin;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = OUT_W'({out_col_q, out_row_q, out_sum_q});
  assign m_axis_tlast  = out_last_q;

  // ---------------------------------------------------------------- assertions
  `MMC_ASSERT_NOW(a_idx_range, clk_i, rst_ni, state_q == ST_CALC,
                  (k_q <= n_m1) && (j_q <= p_m1) && (i_q <= m_m1))
  `MMC_ASSERT_NOW(a_no_rw_overlap, clk_i, rst_ni, issue, !a_we && !b_we)
  `MMC_ASSERT_NOW(a_last_at_corner, clk_i, rst_ni, m_axis_tvalid && m_axis_tlast,
                  (out_row_q == mmc_pkg::IDX_W'(m_m1)) && (out_col_q == mmc_pkg::IDX_W'(p_m1)))
  `MMC_ASSERT_NEXT(a_stall_holds_sum, clk_i, rst_ni, mac_done && !adv, mac_done)

endmodule

// ===== tb/tb_top.sv =====
// testbench for the matrix multiply core: directed and random matrices checked against a predictor
`timescale 1ns / 1ps

module tb_top;
  import mmc_pkg::*;

  localparam int MAX_DIM       = MAX_DIM_DEF;
  localparam int RANDOM_ITEMS  = 160;
  localparam int SETTLE_CYCLES = 8;       // quiet time before a dimension write
  localparam int DRAIN_CYCLES  = 16;      // tail after the last sum has arrived
  localparam int LONG_HOLD     = 2000;    // result side back-pressure episode
  localparam int CYCLE_LIMIT   = 400000;

  // one element of the result matrix
  typedef struct packed {
    logic signed [PRODUCT_W-1:0] value;
    logic [IDX_W-1:0]            row;
    logic [IDX_W-1:0]            col;
    logic                        fin;
  } c_elem_t;

  typedef enum logic [0:0] {
    STEP_CFG,
    STEP_ELEM
  } step_kind_e;

  // one row of the directed table; sum is only used where typed is set
  typedef struct packed {
    step_kind_e                  kind;
    logic [1:0]                  reg_idx;
    logic [15:0]                 value;
    logic                        typed;
    logic signed [PRODUCT_W-1:0] sum;
  } dir_step_t;

  localparam int N_DIR = 32;

  localparam dir_step_t DIR_STEPS [N_DIR] = '{
    // 1x1x1 with extreme operands: one sum per pair of elements
    '{STEP_CFG,  REG_ROWS_A,    16'd1,    1'b0, '0},
    '{STEP_CFG,  REG_INNER_LEN, 16'd1,    1'b0, '0},
    '{STEP_CFG,  REG_COLS_B,    16'd1,    1'b0, '0},
    '{STEP_ELEM, REG_ROWS_A,    16'h8000, 1'b0, '0},
    '{STEP_ELEM, REG_ROWS_A,    16'h8000, 1'b1, 40'sd1073741824},
    '{STEP_ELEM, REG_ROWS_A,    16'h7fff, 1'b0, '0},
    '{STEP_ELEM, REG_ROWS_A,    16'h7fff, 1'b1, 40'sd1073676289},
    '{STEP_ELEM, REG_ROWS_A,    16'h7fff, 1'b0, '0},
    '{STEP_ELEM, REG_ROWS_A,    16'h8000, 1'b1, -40'sd1073709056},
    // zero dimensions behave as one
    '{STEP_CFG,  REG_ROWS_A,    16'd0,    1'b0, '0},
    '{STEP_CFG,  REG_INNER_LEN, 16'd0,    1'b0, '0},
    '{STEP_CFG,  REG_COLS_B,    16'd0,    1'b0, '0},
    '{STEP_ELEM, REG_ROWS_A,    16'hffff, 1'b0, '0},
    '{STEP_ELEM, REG_ROWS_A,    16'h0001, 1'b1, -40'sd1},
    // oversized row count saturates to the maximum: 8x1 times 1x1
    '{STEP_CFG,  REG_ROWS_A,    16'd15,   1'b0, '0},
    '{STEP_ELEM, REG_ROWS_A,    16'h0100, 1'b0, '0},
    '{STEP_ELEM, REG_ROWS_A,    16'hff00, 1'b0, '0},
    '{STEP_ELEM, REG_ROWS_A,    16'h8000, 1'b0, '0},
    '{STEP_ELEM, REG_ROWS_A,    16'h7fff, 1'b0, '0},
    '{STEP_ELEM, REG_ROWS_A,    16'h5555, 1'b0, '0},
    '{STEP_ELEM, REG_ROWS_A,    16'haaaa, 1'b0, '0},
    '{STEP_ELEM, REG_ROWS_A,    16'h0001, 1'b0, '0},
    '{STEP_ELEM, REG_ROWS_A,    16'h0000, 1'b0, '0},
    '{STEP_ELEM, REG_ROWS_A,    16'h8000, 1'b0, '0},
    // a partial load is thrown away by the next dimension write
    '{STEP_CFG,  REG_COLS_B,    16'd2,    1'b0, '0},
    '{STEP_ELEM, REG_ROWS_A,    16'h1234, 1'b0, '0},
    '{STEP_ELEM, REG_ROWS_A,    16'hedcb, 1'b0, '0},
    '{STEP_ELEM, REG_ROWS_A,    16'h00ff, 1'b0, '0},
    '{STEP_CFG,  REG_ROWS_A,    16'd1,    1'b0, '0},
    '{STEP_ELEM, REG_ROWS_A,    16'h0180, 1'b0, '0},
    '{STEP_ELEM, REG_ROWS_A,    16'h7fff, 1'b0, '0},
    '{STEP_ELEM, REG_ROWS_A,    16'h8000, 1'b0, '0}
  };

  localparam logic [1:0] DIM_REGS [3] = '{REG_ROWS_A, REG_INNER_LEN, REG_COLS_B};

  logic                  clk_i;
  logic                  rst_ni;
  logic                  psel;
  logic                  penable;
  logic                  pwrite;
  logic [CFG_ADDR_W-1:0] paddr;
  logic [CFG_DATA_W-1:0] pwdata;
  logic [CFG_DATA_W-1:0] prdata;
  logic                  pready;
  logic                  s_axis_tvalid;
  logic                  s_axis_tready;
  logic [15:0]           s_axis_tdata;   // element_value
  logic                  m_axis_tvalid;
  logic                  m_axis_tready;
  logic [47:0]           m_axis_tdata;   // product_value, out_row, out_col
  logic                  m_axis_tlast;   // last_of_run

  // predictor state: element stores, load position and raw dimension registers
  logic signed [15:0] a_store [MAX_DIM*MAX_DIM];
  logic signed [15:0] b_store [MAX_DIM*MAX_DIM];
  int unsigned        elems_loaded;
  logic [3:0]         dim_raw [4];

  c_elem_t expected_sums [$];
  c_elem_t new_sums [$];

  int  mismatch_count;
  int  cycle_count;
  int  items_sent;
  bit  tx_idle_en;
  bit  rx_idle_en;
  bit  hold_req;

  matrix_multiply_core u_dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .psel          (psel),
    .penable       (penable),
    .pwrite        (pwrite),
    .paddr         (paddr),
    .pwdata        (pwdata),
    .prdata        (prdata),
    .pready        (pready),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tlast  (m_axis_tlast)
  );

  // 10 ns clock
  initial clk_i = 1'b0;
  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // run guard: a hang ends the run as a failure
  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles", cycle_count);
      $display("status: fail");
      $finish;
    end
  end

  // register value to working size: zero acts as one, oversize saturates
  function automatic int unsigned eff_dim(logic [3:0] raw);
    if (raw == 4'd0) return 1;
    if (raw > MAX_DIM) return MAX_DIM;
    return raw;
  endfunction

  function automatic int unsigned load_length();
    int unsigned m, n, p;
    m = eff_dim(dim_raw[REG_ROWS_A]);
    n = eff_dim(dim_raw[REG_INNER_LEN]);
    p = eff_dim(dim_raw[REG_COLS_B]);
    return m * n + n * p;
  endfunction

  // store one element; on the final element of B, queue every sum of C into new_sums
  function automatic void feed_element(logic [15:0] raw);
    int unsigned        m, n, p, size_a, total;
    int unsigned        i, j, k;
    logic signed [63:0] acc;
    m      = eff_dim(dim_raw[REG_ROWS_A]);
    n      = eff_dim(dim_raw[REG_INNER_LEN]);
    p      = eff_dim(dim_raw[REG_COLS_B]);
    size_a = m * n;
    total  = size_a + n * p;
    if (elems_loaded >= total) elems_loaded = 0;
    if (elems_loaded < size_a) a_store[elems_loaded] = raw;
    else b_store[elems_loaded - size_a] = raw;
    elems_loaded++;
    if (elems_loaded < total) return;
    for (i = 0; i < m; i++) begin
      for (j = 0; j < p; j++) begin
        acc = '0;
        for (k = 0; k < n; k++) acc = acc + a_store[i*n + k] * b_store[k*p + j];
        new_sums.push_back('{acc[PRODUCT_W-1:0], i[IDX_W-1:0], j[IDX_W-1:0],
                             (i == m - 1) && (j == p - 1)});
      end
    end
    elems_loaded = 0;
  endfunction

  // one register access: setup phase, then access phase until pready
  task automatic apb_access(bit wr, logic [1:0] idx, logic [31:0] wdata,
                            output logic [31:0] rdata);
    @(negedge clk_i);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= wr;
    paddr   <= {idx, 2'b00};
    pwdata  <= wdata;
    @(negedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    rdata = prdata;
    @(negedge clk_i);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
  endtask

  // dimension write: only once every sum is back and the core has gone quiet
  task automatic write_dim(logic [1:0] idx, logic [3:0] value, bit noisy);
    logic [31:0] wdata;
    logic [31:0] unused;
    @(negedge clk_i);
    s_axis_tvalid <= 1'b0;
    wait (expected_sums.size() == 0);
    repeat (SETTLE_CYCLES) @(negedge clk_i);
    wdata      = noisy ? 32'($urandom) : '0;   // upper bits are ignored by the core
    wdata[3:0] = value;
    apb_access(1'b1, idx, wdata, unused);
    dim_raw[idx] = value;
    elems_loaded = 0;
  endtask

  // offer one element, with an optional idle burst first; returns once transferred
  task automatic push_element(logic [15:0] value, bit typed,
                              logic signed [PRODUCT_W-1:0] typed_sum);
    int gap;
    gap = (tx_idle_en && $urandom_range(0, 3) == 0) ? $urandom_range(1, 11) : 0;
    @(negedge clk_i);
    if (gap > 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= value;
    do @(posedge clk_i); while (!s_axis_tready);
    items_sent++;
    new_sums.delete();
    feed_element(value);
    if (typed) begin
      new_sums.delete();
      new_sums.push_back('{typed_sum, '0, '0, 1'b1});
    end
    foreach (new_sums[q]) expected_sums.push_back(new_sums[q]);
  endtask

  // random element, weighted towards the extremes and small magnitudes
  function automatic logic [15:0] rand_element();
    case ($urandom_range(0, 7))
      0:       return 16'h8000;
      1:       return 16'h7fff;
      2:       return 16'($urandom_range(0, 511) - 256);
      default: return 16'($urandom);
    endcase
  endfunction

  // mostly small sizes, now and then zero or a value at or above the maximum
  function automatic logic [3:0] rand_dim();
    case ($urandom_range(0, 9))
      0:       return 4'd0;
      1:       return 4'($urandom_range(8, 15));
      default: return 4'($urandom_range(1, 3));
    endcase
  endfunction

  task automatic run_matrices(int count, bit allow_partial);
    int unsigned len;
    int unsigned partial;
    for (int r = 0; r < count; r++) begin
      len = load_length();
      for (int unsigned e = 0; e < len; e++) push_element(rand_element(), 1'b0, '0);
    end
    // occasionally leave a broken load behind for the next dimension write to drop
    len = load_length();
    if (allow_partial && len > 1 && $urandom_range(0, 4) == 0) begin
      partial = $urandom_range(1, len - 1);
      for (int unsigned e = 0; e < partial; e++) push_element(rand_element(), 1'b0, '0);
    end
  endtask

  // result side: ready toggles in random bursts, with one long hold-off on request
  initial begin
    int low;
    int high;
    m_axis_tready = 1'b0;
    wait (rst_ni);
    @(negedge clk_i);
    forever begin
      if (hold_req) begin
        hold_req = 1'b0;
        low      = LONG_HOLD;
      end else if (rx_idle_en && $urandom_range(0, 2) == 0) begin
        low = $urandom_range(1, 11);
      end else begin
        low = 0;
      end
      if (low > 0) begin
        m_axis_tready <= 1'b0;
        repeat (low) @(negedge clk_i);
      end
      m_axis_tready <= 1'b1;
      high = $urandom_range(1, 16);
      repeat (high) @(negedge clk_i);
    end
  end

  // result checker: every transfer against the oldest expected sum
  always @(posedge clk_i) begin
    c_elem_t want;
    c_elem_t got;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      got = '{m_axis_tdata[39:0], m_axis_tdata[42:40], m_axis_tdata[45:43], m_axis_tlast};
      if (expected_sums.size() == 0) begin
        mismatch_count++;
        if (mismatch_count <= 10)
          $display("unexpected sum: value %0d row %0d col %0d last %0b",
                   got.value, got.row, got.col, got.fin);
      end else begin
        want = expected_sums.pop_front();
        if (got.value !== want.value || got.row !== want.row ||
            got.col !== want.col || got.fin !== want.fin) begin
          mismatch_count++;
          if (mismatch_count <= 10)
            $display("sum mismatch: expected %0d (%0d,%0d) last %0b, got %0d (%0d,%0d) last %0b",
                     want.value, want.row, want.col, want.fin,
                     got.value, got.row, got.col, got.fin);
        end
      end
    end
  end

  // main sequence
  initial begin
    logic [31:0] rd;
    int          phase;
    psel           = 1'b0;
    penable        = 1'b0;
    pwrite         = 1'b0;
    paddr          = '0;
    pwdata         = '0;
    s_axis_tvalid  = 1'b0;
    s_axis_tdata   = '0;
    mismatch_count = 0;
    cycle_count    = 0;
    items_sent     = 0;
    tx_idle_en     = 1'b1;
    rx_idle_en     = 1'b1;
    hold_req       = 1'b0;
    elems_loaded   = 0;
    foreach (dim_raw[d]) dim_raw[d] = DIM_RESET;
    rst_ni         = 1'b0;
    repeat (12) @(negedge clk_i);
    rst_ni = 1'b1;

    // dimension registers come out of reset at the maximum size
    foreach (DIM_REGS[d]) begin
      apb_access(1'b0, DIM_REGS[d], '0, rd);
      if (rd !== {{(CFG_DATA_W-DIM_REG_W){1'b0}}, DIM_RESET}) begin
        mismatch_count++;
        if (mismatch_count <= 10)
          $display("reset value of register %0d: expected %0d, got %0h", d, DIM_RESET, rd);
      end
    end

    // directed table
    foreach (DIR_STEPS[s]) begin
      if (DIR_STEPS[s].kind == STEP_CFG)
        write_dim(DIR_STEPS[s].reg_idx, DIR_STEPS[s].value[3:0], 1'b0);
      else
        push_element(DIR_STEPS[s].value, DIR_STEPS[s].typed, DIR_STEPS[s].sum);
    end

    // full-size matrices first: 8x8 times 8x8, with inner length given oversize
    items_sent = 0;
    write_dim(REG_ROWS_A, 4'd8, 1'b1);
    write_dim(REG_INNER_LEN, 4'd15, 1'b1);
    write_dim(REG_COLS_B, 4'd8, 1'b1);
    run_matrices(1, 1'b0);

    // random sizes; the first of these runs into a long result-side hold-off
    phase = 0;
    while (items_sent < RANDOM_ITEMS) begin
      tx_idle_en = $urandom_range(0, 3) != 0;
      rx_idle_en = $urandom_range(0, 3) != 0;
      foreach (DIM_REGS[d]) write_dim(DIM_REGS[d], rand_dim(), 1'b1);
      if (phase == 0) begin
        // hold-off starts first, then enough matrices to back up into the input
        hold_req = 1'b1;
        wait (!hold_req);
        run_matrices(4, 1'b1);
      end else begin
        run_matrices($urandom_range(1, 3), 1'b1);
      end
      phase++;
    end

    // closing stretch without any idling
    tx_idle_en = 1'b0;
    rx_idle_en = 1'b0;
    foreach (DIM_REGS[d]) write_dim(DIM_REGS[d], 4'($urandom_range(1, 4)), 1'b1);
    run_matrices(2, 1'b0);

    @(negedge clk_i);
    s_axis_tvalid <= 1'b0;
    wait (expected_sums.size() == 0);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (mismatch_count == 0 && expected_sums.size() == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule
